[sv/sbvc_pkg.sv]
package sbvc_pkg;

	// Sample format: signed, 20 fraction bits.
	localparam int SAMPLE_W = 24;
	localparam int FRAC_W   = 20;

	// Shared multiplier: one signed 25 x 25 product per cycle.
	localparam int MUL_W  = SAMPLE_W + 1;
	localparam int PROD_W = 2 * MUL_W;
	// Five filter products summed with headroom.
	localparam int ACC_W  = PROD_W + 3;
	// Width that a value is brought to before it is saturated to a sample.
	localparam int SAT_W  = 36;

	localparam int PC_W   = 4;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	localparam int PCM_W = 16;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [PCM_W-1:0]    PCM_MAX    = {1'b0, {(PCM_W-1){1'b1}}};
	localparam logic signed [PCM_W-1:0]    PCM_MIN    = {1'b1, {(PCM_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DC_OFFSET = 3'd0,
		REG_LEAK      = 3'd1,
		REG_COEF_B0   = 3'd2,
		REG_COEF_B1   = 3'd3,
		REG_COEF_B2   = 3'd4,
		REG_COEF_A1   = 3'd5,
		REG_COEF_A2   = 3'd6,
		REG_OUT_GAIN  = 3'd7
	} reg_idx_t;

	localparam logic [19:0] DC_OFFSET_RST = 20'd10461;
	localparam logic [14:0] LEAK_RST      = 15'd32113;
	localparam logic [15:0] OUT_GAIN_RST  = 16'd6554;

	typedef struct packed {
		logic signed [23:0] pulse_sample;
		logic [15:0]        envelope;
		logic               restart;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] pcm_out;
		logic               clipped;
	} result_t;

	// Control word fields.
	typedef enum logic [2:0] {
		A_INTEG, A_D, A_XH0, A_XH1, A_YH0, A_YH1, A_Y, A_V
	} a_sel_t;

	typedef enum logic [2:0] {
		B_LEAK, B_B0, B_B1, B_B2, B_A1, B_A2, B_ENV, B_GAIN
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_LOAD, ACT_INTEG, ACT_HIST, ACT_VSCALE, ACT_EMIT
	} act_t;

	typedef enum logic [1:0] {
		HOLD_NONE, HOLD_IN, HOLD_OUT
	} hold_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		logic    mul_en;
		acc_op_t acc_op;
		act_t    act;
		hold_t   hold;
		logic    last;
	} ctrl_t;

	typedef struct packed {
		ctrl_t word;
		logic  go;
	} seq_ctl_t;

	localparam ctrl_t CTRL_NOP = '{
		a_sel:  A_INTEG,
		b_sel:  B_LEAK,
		mul_en: 1'b0,
		acc_op: ACC_NONE,
		act:    ACT_NONE,
		hold:   HOLD_NONE,
		last:   1'b0
	};

	// Microprogram for one sample. A product issued in one step is read
	// from the product register in the next step.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c = CTRL_NOP;
		unique case (pc)
			4'd0: begin
				c.act  = ACT_LOAD;
				c.hold = HOLD_IN;
			end
			4'd1: begin
				c.a_sel  = A_INTEG;
				c.b_sel  = B_LEAK;
				c.mul_en = 1'b1;
			end
			4'd2: begin
				c.act = ACT_INTEG;
			end
			4'd3: begin
				c.a_sel  = A_D;
				c.b_sel  = B_B0;
				c.mul_en = 1'b1;
			end
			4'd4: begin
				c.a_sel  = A_XH0;
				c.b_sel  = B_B1;
				c.mul_en = 1'b1;
				c.acc_op = ACC_LOAD;
			end
			4'd5: begin
				c.a_sel  = A_XH1;
				c.b_sel  = B_B2;
				c.mul_en = 1'b1;
				c.acc_op = ACC_ADD;
			end
			4'd6: begin
				c.a_sel  = A_YH0;
				c.b_sel  = B_A1;
				c.mul_en = 1'b1;
				c.acc_op = ACC_ADD;
			end
			4'd7: begin
				c.a_sel  = A_YH1;
				c.b_sel  = B_A2;
				c.mul_en = 1'b1;
				c.acc_op = ACC_SUB;
			end
			4'd8: begin
				c.acc_op = ACC_SUB;
			end
			4'd9: begin
				c.act = ACT_HIST;
			end
			4'd10: begin
				c.a_sel  = A_Y;
				c.b_sel  = B_ENV;
				c.mul_en = 1'b1;
			end
			4'd11: begin
				c.act = ACT_VSCALE;
			end
			4'd12: begin
				c.a_sel  = A_V;
				c.b_sel  = B_GAIN;
				c.mul_en = 1'b1;
			end
			4'd13: begin
				c.act  = ACT_EMIT;
				c.hold = HOLD_OUT;
				c.last = 1'b1;
			end
			default: begin
				c.last = 1'b1;
			end
		endcase
		return c;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(SAMPLE_MAX);
		lo = SAT_W'(SAMPLE_MIN);
		if (v > hi) begin
			return SAMPLE_MAX;
		end else if (v < lo) begin
			return SAMPLE_MIN;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

[sv/sbvc_seq.sv]
module sbvc_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               out_free,
	output logic               sample_ready,
	output sbvc_pkg::seq_ctl_t ctl
);
	import sbvc_pkg::*;

	logic [PC_W-1:0] pc_q;
	ctrl_t           word;
	logic            go;

	assign word = ucode(pc_q);

	// A step that waits on a handshake repeats until its condition holds.
	always_comb begin
		unique case (word.hold)
			HOLD_IN:  go = sample_valid;
			HOLD_OUT: go = out_free;
			default:  go = 1'b1;
		endcase
	end

	assign sample_ready = (word.hold == HOLD_IN);
	assign ctl.word     = word;
	assign ctl.go       = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (go) begin
			if (word.last) begin
				pc_q <= '0;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

endmodule

[sv/sawtooth_biquad_vca_chain_top.sv]
// Channel   Direction  Handshake                   Payload
// sample    in         sample_valid / sample_ready  sbvc_pkg::sample_t
// result    out        result_valid / result_ready  sbvc_pkg::result_t
// config    in         wr_en (no wait)              wr_index, wr_data
//
// A microprogram of 14 steps drives a single shared 25 x 25 multiplier
// through eight products per sample, at most one per step.
// A new request can be taken on the clock after the result register is loaded;
// the last step waits while the result register still holds an untaken result.
// Reset restores the register defaults and clears the integrator and filter history.
module sawtooth_biquad_vca_chain_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  sbvc_pkg::sample_t                   sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output sbvc_pkg::result_t                   result,
	input  logic                                wr_en,
	input  logic [sbvc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [sbvc_pkg::CFG_DATA_W-1:0]     wr_data
);
	import sbvc_pkg::*;

	localparam logic signed [MUL_W+1:0]  FIRST_HALF = (MUL_W+2)'(1) <<< (FRAC_W - 1);
	localparam logic signed [PROD_W-1:0] LEAK_HALF  = PROD_W'(1) <<< 14;
	localparam logic signed [PROD_W-1:0] ENV_HALF   = PROD_W'(1) <<< 15;
	localparam logic signed [PROD_W-1:0] PCM_HALF   = PROD_W'(1) <<< 20;
	localparam logic signed [ACC_W-1:0]  ACC_HALF   = ACC_W'(1) <<< 20;

	// Registers
	logic [19:0]                dc_offset_q;
	logic [14:0]                leak_q;
	logic signed [23:0]         b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [15:0]                gain_q;

	// Sample state
	logic signed [SAMPLE_W-1:0] pulse_q;
	logic [15:0]                env_q;
	logic signed [SAMPLE_W-1:0] integ_q;
	logic signed [SAMPLE_W-1:0] xh0_q, xh1_q, yh0_q, yh1_q;
	logic                       first_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic signed [SAMPLE_W-1:0] v_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;

	logic                       result_valid_q;
	result_t                    result_q;

	seq_ctl_t                   ctl;
	logic                       out_free;

	assign out_free = !result_valid_q || result_ready;

	sbvc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.out_free     (out_free),
		.sample_ready (sample_ready),
		.ctl          (ctl)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_offset_q <= DC_OFFSET_RST;
			leak_q      <= LEAK_RST;
			b0_q        <= '0;
			b1_q        <= '0;
			b2_q        <= '0;
			a1_q        <= '0;
			a2_q        <= '0;
			gain_q      <= OUT_GAIN_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DC_OFFSET: dc_offset_q <= wr_data[19:0];
				REG_LEAK:      leak_q      <= wr_data[14:0];
				REG_COEF_B0:   b0_q        <= wr_data[23:0];
				REG_COEF_B1:   b1_q        <= wr_data[23:0];
				REG_COEF_B2:   b2_q        <= wr_data[23:0];
				REG_COEF_A1:   a1_q        <= wr_data[23:0];
				REG_COEF_A2:   a2_q        <= wr_data[23:0];
				REG_OUT_GAIN:  gain_q      <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Doubled integrator value, saturated.
	logic signed [SAMPLE_W-1:0] d_w;
	always_comb begin
		if (integ_q[SAMPLE_W-1] == integ_q[SAMPLE_W-2]) begin
			d_w = {integ_q[SAMPLE_W-2:0], 1'b0};
		end else if (integ_q[SAMPLE_W-1]) begin
			d_w = SAMPLE_MIN;
		end else begin
			d_w = SAMPLE_MAX;
		end
	end

	// Multiplier operand selection
	logic signed [MUL_W-1:0] mul_a, mul_b;
	always_comb begin
		unique case (ctl.word.a_sel)
			A_INTEG: mul_a = MUL_W'(integ_q);
			A_D:     mul_a = MUL_W'(d_w);
			A_XH0:   mul_a = MUL_W'(xh0_q);
			A_XH1:   mul_a = MUL_W'(xh1_q);
			A_YH0:   mul_a = MUL_W'(yh0_q);
			A_YH1:   mul_a = MUL_W'(yh1_q);
			A_Y:     mul_a = MUL_W'(y_q);
			A_V:     mul_a = MUL_W'(v_q);
			default: mul_a = '0;
		endcase
		unique case (ctl.word.b_sel)
			B_LEAK:  mul_b = {{(MUL_W-15){1'b0}}, leak_q};
			B_B0:    mul_b = MUL_W'(b0_q);
			B_B1:    mul_b = MUL_W'(b1_q);
			B_B2:    mul_b = MUL_W'(b2_q);
			B_A1:    mul_b = MUL_W'(a1_q);
			B_A2:    mul_b = MUL_W'(a2_q);
			B_ENV:   mul_b = {{(MUL_W-16){1'b0}}, env_q};
			B_GAIN:  mul_b = {{(MUL_W-16){1'b0}}, gain_q};
			default: mul_b = '0;
		endcase
	end

	// Integrator update: pulse minus DC, then either the first-sample offset
	// or the rounded leak term.
	logic signed [MUL_W-1:0]    x_w;
	logic signed [PROD_W-1:0]   leak_rnd_w;
	logic signed [SAMPLE_W-1:0] leak_term_w;
	logic signed [MUL_W+1:0]    s_w;
	assign x_w         = MUL_W'(pulse_q) - $signed({{(MUL_W-20){1'b0}}, dc_offset_q});
	assign leak_rnd_w  = prod_q + LEAK_HALF;
	assign leak_term_w = leak_rnd_w[SAMPLE_W+14:15];
	assign s_w         = first_q ? ((MUL_W+2)'(x_w) - FIRST_HALF)
	                             : ((MUL_W+2)'(x_w) + (MUL_W+2)'(leak_term_w));

	// Filter output rounding
	logic signed [ACC_W-1:0]    acc_rnd_w;
	logic signed [ACC_W-1:0]    acc_shr_w;
	logic signed [SAMPLE_W-1:0] y_w;
	assign acc_rnd_w = acc_q + ACC_HALF;
	assign acc_shr_w = acc_rnd_w >>> 21;
	assign y_w       = sat_sample(acc_shr_w[SAT_W-1:0]);

	// Envelope and gain rounding
	logic signed [PROD_W-1:0] env_rnd_w;
	logic signed [PROD_W-1:0] pcm_rnd_w;
	logic signed [PROD_W-1:0] pcm_shr_w;
	assign env_rnd_w = prod_q + ENV_HALF;
	assign pcm_rnd_w = prod_q + PCM_HALF;
	assign pcm_shr_w = pcm_rnd_w >>> 21;

	result_t pcm_w;
	always_comb begin
		if (pcm_shr_w > PROD_W'(PCM_MAX)) begin
			pcm_w.pcm_out = PCM_MAX;
			pcm_w.clipped = 1'b1;
		end else if (pcm_shr_w < PROD_W'(PCM_MIN)) begin
			pcm_w.pcm_out = PCM_MIN;
			pcm_w.clipped = 1'b1;
		end else begin
			pcm_w.pcm_out = pcm_shr_w[PCM_W-1:0];
			pcm_w.clipped = 1'b0;
		end
	end

	// Datapath without reset
	always_ff @(posedge clk) begin
		if (ctl.go && ctl.word.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (ctl.go) begin
			unique case (ctl.word.acc_op)
				ACC_LOAD: acc_q <= ACC_W'(prod_q);
				ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
				ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_q);
				default: ;
			endcase
		end
		if (ctl.go && ctl.word.act == ACT_LOAD) begin
			pulse_q <= sample.pulse_sample;
			env_q   <= sample.envelope;
		end
		if (ctl.go && ctl.word.act == ACT_HIST) begin
			y_q <= y_w;
		end
		if (ctl.go && ctl.word.act == ACT_VSCALE) begin
			v_q <= env_rnd_w[SAMPLE_W+15:16];
		end
		if (ctl.go && ctl.word.act == ACT_EMIT) begin
			result_q <= pcm_w;
		end
	end

	// Filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			xh0_q   <= '0;
			xh1_q   <= '0;
			yh0_q   <= '0;
			yh1_q   <= '0;
			first_q <= 1'b1;
		end else if (ctl.go) begin
			unique case (ctl.word.act)
				ACT_LOAD: begin
					if (sample.restart) begin
						integ_q <= '0;
						xh0_q   <= '0;
						xh1_q   <= '0;
						yh0_q   <= '0;
						yh1_q   <= '0;
						first_q <= 1'b1;
					end
				end
				ACT_INTEG: begin
					integ_q <= sat_sample(SAT_W'(s_w));
					first_q <= 1'b0;
				end
				ACT_HIST: begin
					xh1_q <= xh0_q;
					xh0_q <= d_w;
					yh1_q <= yh0_q;
					yh0_q <= y_w;
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.go && ctl.word.act == ACT_EMIT) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(ctl.go && ctl.word.act == ACT_EMIT))
		else $error("result became valid without an emit step");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("new request taken while a sample is in progress");

	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.clipped |-> result.pcm_out == PCM_MAX || result.pcm_out == PCM_MIN)
		else $error("clipped flag set on an unsaturated sample");

	a_first_cleared_by_integ: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_q) |-> $past(ctl.go && ctl.word.act == ACT_INTEG))
		else $error("first-sample flag cleared outside the integrator step");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

// Predicts the voice path one request at a time and holds the PCM results still owed.
class voice_path;
	logic [19:0]                          dc_offset;
	logic [14:0]                          leak;
	logic signed [sbvc_pkg::SAMPLE_W-1:0] b0, b1, b2, a1, a2;
	logic [15:0]                          gain;

	logic signed [sbvc_pkg::SAMPLE_W-1:0] integ;
	logic signed [sbvc_pkg::SAMPLE_W-1:0] xh [2];
	logic signed [sbvc_pkg::SAMPLE_W-1:0] yh [2];
	bit                                   first;

	sbvc_pkg::result_t pcm_due [$];
	int mismatches, requests, results, clips, restarts;

	function new();
		dc_offset = sbvc_pkg::DC_OFFSET_RST;
		leak      = sbvc_pkg::LEAK_RST;
		b0        = '0;
		b1        = '0;
		b2        = '0;
		a1        = '0;
		a2        = '0;
		gain      = sbvc_pkg::OUT_GAIN_RST;
		clear_history();
	endfunction

	function void clear_history();
		integ = '0;
		xh[0] = '0;
		xh[1] = '0;
		yh[0] = '0;
		yh[1] = '0;
		first = 1'b1;
	endfunction

	function void set_reg(sbvc_pkg::reg_idx_t idx, logic [23:0] data);
		case (idx)
			sbvc_pkg::REG_DC_OFFSET: dc_offset = data[19:0];
			sbvc_pkg::REG_LEAK:      leak = data[14:0];
			sbvc_pkg::REG_COEF_B0:   b0 = data;
			sbvc_pkg::REG_COEF_B1:   b1 = data;
			sbvc_pkg::REG_COEF_B2:   b2 = data;
			sbvc_pkg::REG_COEF_A1:   a1 = data;
			sbvc_pkg::REG_COEF_A2:   a2 = data;
			sbvc_pkg::REG_OUT_GAIN:  gain = data[15:0];
			default: ;
		endcase
	endfunction

	// Add half an LSB, then shift with floor.
	function longint rnd_shift(longint v, int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function logic signed [sbvc_pkg::SAMPLE_W-1:0] sat24(longint v);
		if (v > longint'(sbvc_pkg::SAMPLE_MAX)) return sbvc_pkg::SAMPLE_MAX;
		if (v < longint'(sbvc_pkg::SAMPLE_MIN)) return sbvc_pkg::SAMPLE_MIN;
		return sbvc_pkg::SAMPLE_W'(v);
	endfunction

	function void take_sample(sbvc_pkg::sample_t s);
		longint                               x, sum, acc, v, p;
		logic signed [sbvc_pkg::SAMPLE_W-1:0] d, y;
		sbvc_pkg::result_t                    r;
		requests++;
		if (s.restart) begin
			clear_history();
			restarts++;
		end
		x = longint'($signed(s.pulse_sample)) - longint'(dc_offset);
		// With no history yet, the sawtooth starts half a unit down.
		if (first) sum = x - (longint'(1) <<< (sbvc_pkg::FRAC_W - 1));
		else sum = x + rnd_shift(longint'(leak) * longint'(integ), 15);
		integ = sat24(sum);
		first = 1'b0;
		d = sat24(2 * longint'(integ));
		acc = longint'(b0) * longint'(d) + longint'(b1) * longint'(xh[0])
			+ longint'(b2) * longint'(xh[1]) - longint'(a1) * longint'(yh[0])
			- longint'(a2) * longint'(yh[1]);
		y = sat24(rnd_shift(acc, 21));
		xh[1] = xh[0];
		xh[0] = d;
		yh[1] = yh[0];
		yh[0] = y;
		v = rnd_shift(longint'(y) * longint'(s.envelope), 16);
		p = rnd_shift(v * longint'(gain), 16 + sbvc_pkg::FRAC_W - 15);
		r.clipped = 1'b1;
		if (p > longint'(sbvc_pkg::PCM_MAX)) begin
			r.pcm_out = sbvc_pkg::PCM_MAX;
		end else if (p < longint'(sbvc_pkg::PCM_MIN)) begin
			r.pcm_out = sbvc_pkg::PCM_MIN;
		end else begin
			r.pcm_out = sbvc_pkg::PCM_W'(p);
			r.clipped = 1'b0;
		end
		if (r.clipped) clips++;
		pcm_due.push_back(r);
	endfunction

	task report(string msg);
		mismatches++;
		$display("MISMATCH: %s", msg);
	endtask

	task check_pcm(sbvc_pkg::result_t got);
		sbvc_pkg::result_t want;
		results++;
		if (pcm_due.size() == 0) begin
			report($sformatf("result %0d arrived with no request outstanding", results));
			return;
		end
		want = pcm_due.pop_front();
		if (got.pcm_out !== want.pcm_out)
			report($sformatf("result %0d pcm_out %0d, predicted %0d", results,
				$signed(got.pcm_out), $signed(want.pcm_out)));
		if (got.clipped !== want.clipped)
			report($sformatf("result %0d clipped %b, predicted %b", results,
				got.clipped, want.clipped));
	endtask
endclass

module tb;
	import sbvc_pkg::*;

	typedef enum int {SET_RANDOM, SET_LOWPASS, SET_EXTREME} setting_kind_t;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	sample_t              sample       = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 wr_en        = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index     = '0;
	logic [CFG_DATA_W-1:0] wr_data     = '0;

	voice_path model = new();

	bit idle_on      = 1'b1;
	int hold_reqs    = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int pulse_period = 37;
	int pulse_tick   = 0;
	int n_settings   = 0;

	sawtooth_biquad_vca_chain_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid && sample_ready) model.take_sample(sample);
		if (arst_n && result_valid && result_ready) model.check_pcm(result);
	end

	// Result side: random back-pressure while idle_on is set, plus a long hold-off whenever one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !idle_on || ($urandom_range(99) >= 29);
			end
		end
	end

	function automatic sample_t mk(logic [23:0] pulse, logic [15:0] env, logic rst);
		sample_t s;
		s.pulse_sample = pulse;
		s.envelope     = env;
		s.restart      = rst;
		return s;
	endfunction

	// Mostly a pulse train with noise, some full-range, extreme and zero samples.
	function automatic sample_t draw_sample();
		sample_t s;
		int      kind;
		int      env_kind;
		kind     = $urandom_range(9);
		env_kind = $urandom_range(9);
		s.restart = ($urandom_range(99) < 3);
		if (s.restart) pulse_tick = 0;
		if (env_kind == 0) s.envelope = '0;
		else if (env_kind == 1) s.envelope = '1;
		else s.envelope = 16'($urandom);
		if (kind <= 5) begin
			s.pulse_sample = 24'(int'($urandom_range(4095)) - 2048
				+ ((pulse_tick == 0) ? (1 << FRAC_W) : 0));
			pulse_tick = (pulse_tick + 1) % pulse_period;
		end else if (kind <= 7) begin
			s.pulse_sample = 24'($urandom);
		end else if (kind == 8) begin
			s.pulse_sample = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
		end else begin
			s.pulse_sample = '0;
		end
		return s;
	endfunction

	task automatic send_sample(sample_t s);
		int gap;
		gap = 0;
		while (idle_on && $urandom_range(99) < 29) gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
	endtask

	// Drop the request line and wait until every result has come back.
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (model.pcm_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic poke_reg(reg_idx_t idx, logic [23:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		model.set_reg(idx, data);
	endtask

	task automatic load_settings(setting_kind_t kind);
		logic [23:0] val [8];
		reg_idx_t    r;
		int          b0v, a2v;
		r = r.first();
		do begin
			if (kind == SET_EXTREME) val[r] = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			else val[r] = 24'($urandom);
			r = r.next();
		end while (r != r.first());
		if (kind == SET_EXTREME) begin
			// Unsigned registers take all zeros or all ones.
			val[REG_DC_OFFSET] = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
			val[REG_LEAK]      = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
			val[REG_OUT_GAIN]  = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
		end else if (kind == SET_LOWPASS) begin
			// A stable lowpass: both poles stay inside the unit circle.
			b0v = $urandom_range(1 << 17);
			a2v = $urandom_range(1342177, 1971323);
			val[REG_DC_OFFSET] = 24'($urandom_range(20000));
			val[REG_LEAK]      = 24'($urandom_range(29000, 32767));
			val[REG_COEF_B0]   = 24'(b0v);
			val[REG_COEF_B1]   = 24'(2 * b0v);
			val[REG_COEF_B2]   = 24'(b0v);
			val[REG_COEF_A1]   = 24'(-(a2v + (1 << 21) - int'($urandom_range(1 << 17, 1 << 19))));
			val[REG_COEF_A2]   = 24'(a2v);
			val[REG_OUT_GAIN]  = 24'($urandom_range(65535));
		end
		r = r.first();
		do begin
			poke_reg(r, val[r]);
			r = r.next();
		end while (r != r.first());
		wr_en <= 1'b0;
		n_settings++;
	endtask

	initial begin
		setting_kind_t kind;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: zero filter taps, so every result must be silent.
		send_sample(mk(24'h100000, 16'hFFFF, 1'b0));
		send_sample(mk(SAMPLE_MAX, 16'hFFFF, 1'b0));
		send_sample(mk(SAMPLE_MIN, 16'h8000, 1'b1));
		settle();

		// Unity filter, full gain, the largest leak setting, no DC removal.
		poke_reg(REG_DC_OFFSET, 24'h0);
		poke_reg(REG_LEAK, 24'h7FFF);
		poke_reg(REG_COEF_B0, 24'h200000);
		poke_reg(REG_COEF_B1, 24'h0);
		poke_reg(REG_COEF_B2, 24'h0);
		poke_reg(REG_COEF_A1, 24'h0);
		poke_reg(REG_COEF_A2, 24'h0);
		poke_reg(REG_OUT_GAIN, 24'hFFFF);
		wr_en <= 1'b0;
		n_settings++;
		send_sample(mk(SAMPLE_MAX, 16'hFFFF, 1'b1));
		send_sample(mk(SAMPLE_MAX, 16'hFFFF, 1'b0));
		send_sample(mk(SAMPLE_MAX, 16'h8000, 1'b0));
		send_sample(mk(SAMPLE_MIN, 16'hFFFF, 1'b0));
		send_sample(mk(SAMPLE_MIN, 16'hFFFF, 1'b0));
		send_sample(mk(SAMPLE_MIN, 16'h0000, 1'b0));
		send_sample(mk(SAMPLE_MIN, 16'hFFFF, 1'b1));
		send_sample(mk(24'h0, 16'hFFFF, 1'b1));
		send_sample(mk(24'h0, 16'hFFFF, 1'b1));
		send_sample(mk(24'h100000, 16'h0001, 1'b0));
		send_sample(mk(24'h0, 16'h0100, 1'b0));
		send_sample(mk(24'h000400, 16'hFFFF, 1'b0));
		settle();

		load_settings(SET_EXTREME);
		send_sample(mk(SAMPLE_MAX, 16'hFFFF, 1'b1));
		send_sample(mk(SAMPLE_MIN, 16'hFFFF, 1'b0));
		send_sample(mk(24'h0, 16'h0000, 1'b0));
		send_sample(mk(SAMPLE_MAX, 16'hFFFF, 1'b0));
		send_sample(mk(24'hFFFFFF, 16'h7FFF, 1'b0));
		settle();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 2 || ph == 7) kind = SET_EXTREME;
			else if (ph % 2 == 0) kind = SET_LOWPASS;
			else kind = SET_RANDOM;
			load_settings(kind);
			pulse_period = $urandom_range(6, 120);
			pulse_tick   = 0;
			idle_on      = (ph != 3);
			// The result side stalls for a long while; the block must back up.
			if (ph == 5) hold_reqs++;
			for (int i = 0; i < 150; i++) send_sample(draw_sample());
			settle();
		end

		$display("Ran %0d requests under %0d register settings with %0d restarts.",
			model.requests, n_settings, model.restarts);
		$display("Checked %0d results, %0d of them saturated; %0d mismatches.",
			model.results, model.clips, model.mismatches);
		if (model.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
